// ===== rtl/core/fbw_pkg.sv =====
// Package for the bilinear flow warp core: defaults, register and opcode codes,
// configuration and status structs. No dependencies.
package fbw_pkg;

  localparam int DEF_MAX_WIDTH      = 512;
  localparam int DEF_MAX_HEIGHT     = 512;
  localparam int DEF_SAMPLE_BITS    = 16;
  localparam int DEF_FLOW_FRAC_BITS = 5;

  localparam int CFG_BITS       = 10;
  localparam int FLOW_BITS      = 17;
  localparam int PORT_SAMPLE    = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int OUT_DEPTH      = 8;
  localparam int OUT_LEVEL_BITS = 4;
  localparam int FLIGHT_BITS    = 3;

  typedef enum logic [1:0] {
    REG_PLANE_WIDTH  = 2'd0,
    REG_PLANE_HEIGHT = 2'd1,
    REG_SHIFT_X      = 2'd2,
    REG_SHIFT_Y      = 2'd3
  } reg_index_t;

  typedef enum logic {
    OP_LOAD       = 1'b0,
    OP_COMPENSATE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] plane_width;
    logic [CFG_BITS-1:0] plane_height;
    logic [1:0]          shift_x;
    logic [1:0]          shift_y;
  } cfg_t;

  typedef struct packed {
    logic                      out_push;
    logic                      out_full;
    logic [OUT_LEVEL_BITS-1:0] out_level;
    logic [FLIGHT_BITS-1:0]    in_flight;
  } back_status_t;

endpackage

// ===== rtl/core/flow_bilinear_warp_core.sv =====
// Bilinear backward-warp motion compensation of one plane, top level.
// Holds the configuration registers; depends on fbw_pkg, fbw_front, fbw_queue, fbw_back.
//
// Usage:
//   s_axis: tuser = opcode (0 load, 1 compensate); tdata = sample, flow_x, flow_y.
//   Load items fill the frame store in raster order; compensate items follow in
//   raster order and each gives one result on m_axis: tdata = pixel,
//   tuser = passed_through (target outside the plane), tlast = last pixel of plane.
//   Configuration: cfg_we with cfg_index / cfg_data, written while the core is idle.
//   Throughput: one item per cycle while s_axis_tready is high, loads and compensates
//   alike. The four neighbours come from two copies of the frame store, each read
//   at two addresses per cycle.
//   Path from acceptance to m_axis: input queue, row-address multiply, address add
//   with store read, two blend stages, output FIFO.
//   Reset: counters return to zero, registers take width 512, height 512 and
//   zero shifts; the frame store keeps no reset value and needs no clearing.
//   Stall: results collect in an eight-entry output FIFO; the back end stops
//   draining the four-entry input queue when the FIFO could overflow, and
//   s_axis_tready falls once that queue is full.
module flow_bilinear_warp_core #(
  parameter int MAX_WIDTH      = fbw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = fbw_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS    = fbw_pkg::DEF_SAMPLE_BITS,
  parameter int FLOW_FRAC_BITS = fbw_pkg::DEF_FLOW_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [55:0]                    s_axis_tdata,  // sample[15:0], flow_x[32:16], flow_y[49:33]
  input  logic                           s_axis_tuser,  // opcode
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [15:0]                    m_axis_tdata,  // pixel[15:0]
  output logic                           m_axis_tuser,  // passed_through
  output logic                           m_axis_tlast,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [fbw_pkg::CFG_BITS-1:0]   cfg_data
);
  import fbw_pkg::*;

  localparam int F   = FLOW_FRAC_BITS;
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int TW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int EW  = 3 + SAMPLE_BITS + XW + YW + 2*F + AW;
  localparam int CMP = 14;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cfg_t          cfg;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [TW-1:0] total;

  logic           q_push;
  logic           q_pop;
  logic [EW-1:0]  q_din;
  logic [EW-1:0]  q_dout;
  logic           q_full;
  logic           q_empty;
  logic [QCW-1:0] q_level;
  back_status_t   status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plane_width  <= CFG_BITS'(512);
      cfg.plane_height <= CFG_BITS'(512);
      cfg.shift_x      <= '0;
      cfg.shift_y      <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PLANE_WIDTH:  cfg.plane_width  <= cfg_data;
        REG_PLANE_HEIGHT: cfg.plane_height <= cfg_data;
        REG_SHIFT_X:      cfg.shift_x      <= cfg_data[1:0];
        REG_SHIFT_Y:      cfg.shift_y      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes into 1..max
  always_comb begin
    if (cfg.plane_width == '0) begin
      eff_w = WW'(1);
    end else if (CMP'(cfg.plane_width) > CMP'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(cfg.plane_width);
    end
    if (cfg.plane_height == '0) begin
      eff_h = HW'(1);
    end else if (CMP'(cfg.plane_height) > CMP'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(cfg.plane_height);
    end
    total = TW'((WW+HW)'(eff_w) * (WW+HW)'(eff_h));
  end

  fbw_front #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .FLOW_FRAC_BITS (FLOW_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .total     (total),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_sample (s_axis_tdata[15:0]),
    .in_flow_x (s_axis_tdata[32:16]),
    .in_flow_y (s_axis_tdata[49:33]),
    .q_push    (q_push),
    .q_data    (q_din),
    .q_full    (q_full)
  );

  fbw_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty),
    .count (q_level)
  );

  fbw_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .FLOW_FRAC_BITS (FLOW_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .eff_w      (eff_w),
    .q_empty    (q_empty),
    .q_data     (q_dout),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_pixel  (m_axis_tdata),
    .out_passed (m_axis_tuser),
    .out_last   (m_axis_tlast),
    .status     (status)
  );

  a_no_out_overflow: assert property (@(posedge clk) disable iff (rst)
    status.out_push |-> !status.out_full)
    else $error("result pushed into full output FIFO");

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    ((OUT_LEVEL_BITS+1)'(status.out_level) + (OUT_LEVEL_BITS+1)'(status.in_flight))
      <= (OUT_LEVEL_BITS+1)'(OUT_DEPTH))
    else $error("items in flight exceed output FIFO room");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= QCW'(QUEUE_DEPTH))
    else $error("input queue holds more items than its depth");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result shown straight after reset");

endmodule

// ===== rtl/core/fbw_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module fbw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/core/fbw_queue.sv =====
// Small register FIFO with occupancy count.
// No dependencies; DEPTH is a power of two.
module fbw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    head;
  logic [PW-1:0]    tail;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[head];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/fbw_front.sv =====
// Front end: accepts items, runs the load and raster counters, works out the
// target position and classifies it. Depends on fbw_pkg.
module fbw_front #(
  parameter int MAX_WIDTH      = 512,
  parameter int MAX_HEIGHT     = 512,
  parameter int SAMPLE_BITS    = 16,
  parameter int FLOW_FRAC_BITS = 5
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  fbw_pkg::cfg_t                                 cfg,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]                eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]               eff_h,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0]     total,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic                                          in_op,
  input  logic [fbw_pkg::PORT_SAMPLE-1:0]               in_sample,
  input  logic [fbw_pkg::FLOW_BITS-1:0]                 in_flow_x,
  input  logic [fbw_pkg::FLOW_BITS-1:0]                 in_flow_y,
  output logic                                          q_push,
  output logic [3+SAMPLE_BITS+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)
                +2*FLOW_FRAC_BITS+$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] q_data,
  input  logic                                          q_full
);
  import fbw_pkg::*;

  localparam int F   = FLOW_FRAC_BITS;
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int TW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LW  = AW + TW;
  localparam int PXW = ((XW + F) > FLOW_BITS ? (XW + F) : FLOW_BITS) + 2;
  localparam int PYW = ((YW + F) > FLOW_BITS ? (YW + F) : FLOW_BITS) + 2;

  logic [AW-1:0] la;
  logic [XW-1:0] col;
  logic [YW-1:0] row;

  logic                   acc;
  logic                   is_load;
  logic [SAMPLE_BITS-1:0] smp;
  logic [AW-1:0]          la_cur;
  logic [AW:0]            la_inc;
  logic [AW-1:0]          la_next;
  logic                   col_wrap;
  logic                   row_wrap;
  logic signed [FLOW_BITS-1:0] vx;
  logic signed [FLOW_BITS-1:0] vy;
  logic signed [PXW-1:0]  px;
  logic signed [PYW-1:0]  py;
  logic signed [PXW-1:0]  limx;
  logic signed [PYW-1:0]  limy;
  logic                   outside;
  logic                   last;

  assign in_ready = !q_full;
  assign acc      = in_valid && !q_full;
  assign q_push   = acc;
  assign is_load  = (opcode_t'(in_op) == OP_LOAD);
  assign smp      = in_sample[SAMPLE_BITS-1:0];

  // restart the load address when the plane shrank under it
  always_comb begin
    la_cur  = (LW'(la) >= LW'(total)) ? '0 : la;
    la_inc  = (AW+1)'(la_cur) + 1'b1;
    la_next = (LW'(la_inc) >= LW'(total)) ? '0 : la_inc[AW-1:0];
  end

  assign col_wrap = ((XW+1)'(col) + 1'b1) >= (XW+1)'(eff_w);
  assign row_wrap = ((YW+1)'(row) + 1'b1) >= (YW+1)'(eff_h);
  assign last     = col_wrap && row_wrap;

  always_comb begin
    vx   = $signed(in_flow_x) >>> cfg.shift_x;
    vy   = $signed(in_flow_y) >>> cfg.shift_y;
    px   = $signed(PXW'({col, {F{1'b0}}})) + PXW'(vx);
    py   = $signed(PYW'({row, {F{1'b0}}})) + PYW'(vy);
    limx = $signed(PXW'({eff_w - WW'(1), {F{1'b0}}}));
    limy = $signed(PYW'({eff_h - HW'(1), {F{1'b0}}}));
    outside = (px < 0) || (px > limx) || (py < 0) || (py > limy);
  end

  assign q_data = {in_op, outside, last, smp,
                   px[F +: XW], py[F +: YW], px[F-1:0], py[F-1:0], la_cur};

  always_ff @(posedge clk) begin
    if (rst) begin
      la  <= '0;
      col <= '0;
      row <= '0;
    end else if (acc) begin
      if (is_load) begin
        la <= la_next;
      end else if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/fbw_back.sv =====
// Back end: drains the item queue, writes the frame store, fetches the four
// neighbours and blends them; results wait in an output FIFO.
// Depends on fbw_pkg, fbw_ram, fbw_queue.
module fbw_back #(
  parameter int MAX_WIDTH      = 512,
  parameter int MAX_HEIGHT     = 512,
  parameter int SAMPLE_BITS    = 16,
  parameter int FLOW_FRAC_BITS = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   eff_w,
  input  logic                             q_empty,
  input  logic [3+SAMPLE_BITS+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)
                +2*FLOW_FRAC_BITS+$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fbw_pkg::PORT_SAMPLE-1:0]  out_pixel,
  output logic                             out_passed,
  output logic                             out_last,
  output fbw_pkg::back_status_t            status
);
  import fbw_pkg::*;

  localparam int F     = FLOW_FRAC_BITS;
  localparam int SB    = SAMPLE_BITS;
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = 3 + SB + XW + YW + 2*F + AW;
  localparam int RW    = SB + F + 1;
  localparam int VW    = SB + 2*F + 1;
  localparam int OW    = SB + 2;
  localparam int ONE   = 1 << F;

  // stage registers
  logic          s1_v, s2_v, s3_v, s4_v;
  logic [EW-1:0] s1_e, s2_e, s3_e, s4_e;
  logic [AW-1:0] s2_prod;
  logic [RW-1:0] s4_r1, s4_r2;

  logic            op1, pas1, last1;
  logic [SB-1:0]   smp1;
  logic [XW-1:0]   x1_1;
  logic [YW-1:0]   y1_1;
  logic [F-1:0]    fx1, fy1;
  logic [AW-1:0]   la1;
  logic            op2, pas2, last2;
  logic [SB-1:0]   smp2;
  logic [XW-1:0]   x1_2;
  logic [YW-1:0]   y1_2;
  logic [F-1:0]    fx2, fy2;
  logic [AW-1:0]   la2;
  logic            op3, pas3, last3;
  logic [SB-1:0]   smp3;
  logic [XW-1:0]   x1_3;
  logic [YW-1:0]   y1_3;
  logic [F-1:0]    fx3, fy3;
  logic [AW-1:0]   la3;
  logic            op4, pas4, last4;
  logic [SB-1:0]   smp4;
  logic [XW-1:0]   x1_4;
  logic [YW-1:0]   y1_4;
  logic [F-1:0]    fx4, fy4;
  logic [AW-1:0]   la4;

  logic [AW-1:0]   addr;
  logic [AW-1:0]   addr_dn;
  logic            wr_en;
  logic [SB-1:0]   q00, q01, q10, q11;
  logic [SB-1:0]   b, c, d;
  logic [F:0]      wx, wy;
  logic [VW-1:0]   blend;
  logic [SB-1:0]   pix;

  logic                      out_push;
  logic [OW-1:0]             out_din;
  logic [OW-1:0]             out_dout;
  logic                      out_full;
  logic                      out_empty;
  logic [OUT_LEVEL_BITS-1:0] out_level;
  logic [FLIGHT_BITS-1:0]    in_flight;

  assign {op1, pas1, last1, smp1, x1_1, y1_1, fx1, fy1, la1} = s1_e;
  assign {op2, pas2, last2, smp2, x1_2, y1_2, fx2, fy2, la2} = s2_e;
  assign {op3, pas3, last3, smp3, x1_3, y1_3, fx3, fy3, la3} = s3_e;
  assign {op4, pas4, last4, smp4, x1_4, y1_4, fx4, fy4, la4} = s4_e;

  // pop only with room reserved for everything already in the pipe
  assign in_flight = FLIGHT_BITS'(s1_v) + FLIGHT_BITS'(s2_v)
                   + FLIGHT_BITS'(s3_v) + FLIGHT_BITS'(s4_v);
  assign q_pop = !q_empty &&
                 ((OUT_LEVEL_BITS+1)'(out_level) + (OUT_LEVEL_BITS+1)'(in_flight)
                  < (OUT_LEVEL_BITS+1)'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= q_pop;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_e    <= q_data;
    s2_e    <= s1_e;
    s3_e    <= s2_e;
    s4_e    <= s3_e;
    s2_prod <= AW'((YW+WW)'(y1_1) * (YW+WW)'(eff_w));
    s4_r1   <= RW'(q00) * RW'(wx) + RW'(b) * RW'(fx3);
    s4_r2   <= RW'(c) * RW'(wx) + RW'(d) * RW'(fx3);
  end

  // row-above pair from one copy, row-below pair from the other
  assign addr    = s2_prod + AW'(x1_2);
  assign addr_dn = addr + AW'(eff_w);
  assign wr_en   = s2_v && (opcode_t'(op2) == OP_LOAD);

  fbw_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_ram_up (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (la2),
    .wdata   (smp2),
    .raddr_a (addr),
    .raddr_b (addr + 1'b1),
    .rdata_a (q00),
    .rdata_b (q01)
  );

  fbw_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_ram_dn (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (la2),
    .wdata   (smp2),
    .raddr_a (addr_dn),
    .raddr_b (addr_dn + 1'b1),
    .rdata_a (q10),
    .rdata_b (q11)
  );

  // drop neighbours that carry no weight
  always_comb begin
    b  = (fx3 != '0) ? q01 : '0;
    c  = (fy3 != '0) ? q10 : '0;
    d  = (fx3 != '0 && fy3 != '0) ? q11 : '0;
    wx = (F+1)'(ONE) - (F+1)'(fx3);
    wy = (F+1)'(ONE) - (F+1)'(fy4);
    blend = VW'(s4_r1) * VW'(wy) + VW'(s4_r2) * VW'(fy4);
    pix   = blend[2*F +: SB];
  end

  assign out_push = s4_v && (opcode_t'(op4) == OP_COMPENSATE);
  assign out_din  = {pas4, last4, pas4 ? smp4 : pix};

  fbw_queue #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_din),
    .pop   (out_valid && out_ready),
    .dout  (out_dout),
    .full  (out_full),
    .empty (out_empty),
    .count (out_level)
  );

  assign out_valid  = !out_empty;
  assign out_passed = out_dout[OW-1];
  assign out_last   = out_dout[OW-2];
  assign out_pixel  = PORT_SAMPLE'(out_dout[SB-1:0]);

  assign status = '{out_push: out_push, out_full: out_full,
                    out_level: out_level, in_flight: in_flight};

endmodule

// ===== tb/fbw_checker.sv =====
// Scoreboard for flow_bilinear_warp_core: mirrors the frame store, raster counters
// and registers from the observed ports and checks every result. Depends on fbw_pkg.
`timescale 1ns / 1ps

module fbw_checker
  import fbw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [55:0]         s_axis_tdata,   // sample[15:0], flow_x[32:16], flow_y[49:33]
  input  logic                s_axis_tuser,   // opcode
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [15:0]         m_axis_tdata,   // pixel[15:0]
  input  logic                m_axis_tuser,   // passed_through
  input  logic                m_axis_tlast,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  output int                  errors,
  output int                  pending,
  output int                  pixels_seen,
  output int                  passes_seen
);

  localparam int FRAC = DEF_FLOW_FRAC_BITS;
  localparam longint ONE = longint'(1) << FRAC;

  typedef struct {
    logic [15:0] pixel;
    logic        passed;
    logic        last;
  } warp_result_t;

  warp_result_t warped_q[$];

  bit   [15:0]         ref_plane [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
  logic [CFG_BITS-1:0] width_reg, height_reg;
  logic [1:0]          shx_reg, shy_reg;
  int unsigned         load_addr, col, row;

  function automatic int unsigned clamp_size(logic [CFG_BITS-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic longint fetch(longint x, longint y, int unsigned w);
    longint a;
    a = y * w + x;
    return (a < DEF_MAX_WIDTH * DEF_MAX_HEIGHT) ? longint'(ref_plane[a]) : 0;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want, pixels_seen);
    errors++;
  endtask

  task automatic warp_pixel(logic [15:0] smp, logic [16:0] fxr, logic [16:0] fyr);
    int unsigned  w, h;
    longint       vx, vy, px, py, x1, y1, x2, y2, fx, fy, r1, r2;
    warp_result_t res;
    w  = clamp_size(width_reg, DEF_MAX_WIDTH);
    h  = clamp_size(height_reg, DEF_MAX_HEIGHT);
    vx = $signed(fxr);
    vy = $signed(fyr);
    px = longint'(col) * ONE + (vx >>> shx_reg);
    py = longint'(row) * ONE + (vy >>> shy_reg);
    if (px < 0 || px > longint'(w - 1) * ONE || py < 0 || py > longint'(h - 1) * ONE) begin
      res.pixel  = smp;
      res.passed = 1'b1;
    end else begin
      x1 = px >> FRAC;
      y1 = py >> FRAC;
      fx = px & (ONE - 1);
      fy = py & (ONE - 1);
      x2 = x1 + (fx != 0);
      y2 = y1 + (fy != 0);
      r1 = fetch(x1, y1, w) * (ONE - fx) + fetch(x2, y1, w) * fx;
      r2 = fetch(x1, y2, w) * (ONE - fx) + fetch(x2, y2, w) * fx;
      res.pixel  = 16'((r1 * (ONE - fy) + r2 * fy) >> (2 * FRAC));
      res.passed = 1'b0;
    end
    res.last = 1'b0;
    if (col + 1 >= w) begin
      col = 0;
      if (row + 1 >= h) begin
        row = 0;
        res.last = 1'b1;
      end else begin
        row++;
      end
    end else begin
      col++;
    end
    warped_q.push_back(res);
  endtask

  task automatic store_sample(logic [15:0] smp);
    int unsigned total;
    total = clamp_size(width_reg, DEF_MAX_WIDTH) * clamp_size(height_reg, DEF_MAX_HEIGHT);
    if (load_addr >= total) load_addr = 0;
    ref_plane[load_addr] = smp;
    load_addr = (load_addr + 1 >= total) ? 0 : load_addr + 1;
  endtask

  initial begin
    errors      = 0;
    pixels_seen = 0;
    passes_seen = 0;
  end

  always @(posedge clk) begin
    warp_result_t want;
    if (rst) begin
      width_reg  = CFG_BITS'(DEF_MAX_WIDTH);
      height_reg = CFG_BITS'(DEF_MAX_HEIGHT);
      shx_reg    = 2'd0;
      shy_reg    = 2'd0;
      load_addr  = 0;
      col        = 0;
      row        = 0;
      warped_q.delete();
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_PLANE_WIDTH:  width_reg  = cfg_data;
          REG_PLANE_HEIGHT: height_reg = cfg_data;
          REG_SHIFT_X:      shx_reg    = cfg_data[1:0];
          REG_SHIFT_Y:      shy_reg    = cfg_data[1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        pixels_seen++;
        if (m_axis_tuser) passes_seen++;
        if (warped_q.size() == 0) begin
          report("results outstanding", 1, 0);
        end else begin
          want = warped_q.pop_front();
          if (m_axis_tdata !== want.pixel) report("pixel", m_axis_tdata, want.pixel);
          if (m_axis_tuser !== want.passed) report("passed_through", m_axis_tuser, want.passed);
          if (m_axis_tlast !== want.last) report("last_of_plane", m_axis_tlast, want.last);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (opcode_t'(s_axis_tuser) == OP_LOAD) store_sample(s_axis_tdata[15:0]);
        else warp_pixel(s_axis_tdata[15:0], s_axis_tdata[32:16], s_axis_tdata[49:33]);
      end
    end
    pending = warped_q.size();
  end

endmodule

// ===== tb/flow_bilinear_warp_core_tb.sv =====
// Testbench top for flow_bilinear_warp_core: clock, reset, register writes, plane
// loads and flow stimulus with random gaps. Depends on fbw_pkg and fbw_checker.
`timescale 1ns / 1ps

module flow_bilinear_warp_core_tb;
  import fbw_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [55:0]         s_axis_tdata = '0;   // sample[15:0], flow_x[32:16], flow_y[49:33]
  logic                s_axis_tuser = 1'b0; // opcode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;        // pixel[15:0]
  logic                m_axis_tuser;        // passed_through
  logic                m_axis_tlast;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  int errors, pending, pixels_seen, passes_seen;
  int loads_sent, warps_sent;
  bit send_gaps, sink_stalls;
  int stall_left;
  int cur_w, cur_h, cur_sx, cur_sy;
  int covered;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  flow_bilinear_warp_core uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fbw_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending),
    .pixels_seen(pixels_seen), .passes_seen(passes_seen)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Sink: with stalls on, hold a random ready level for stretches of random length; else stay ready.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!sink_stalls) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= $urandom_range(0, 2) != 0 ? 1'b1 : 1'b0;
      stall_left    <= pick_gap();
    end
  end

  task automatic send_item(opcode_t op, logic [15:0] smp, logic [16:0] fx, logic [16:0] fy);
    int gap;
    gap = send_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, fy, fx, smp};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == OP_LOAD) loads_sent++;
    else warps_sent++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // loads leave no result behind, so allow the pipeline to drain
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(int w, int h, int sx, int sy);
    int ew, eh;
    cfg_we    <= 1'b1;
    cfg_index <= REG_PLANE_WIDTH;
    cfg_data  <= CFG_BITS'(w);
    @(posedge clk);
    cfg_index <= REG_PLANE_HEIGHT;
    cfg_data  <= CFG_BITS'(h);
    @(posedge clk);
    cfg_index <= REG_SHIFT_X;
    cfg_data  <= CFG_BITS'(sx);
    @(posedge clk);
    cfg_index <= REG_SHIFT_Y;
    cfg_data  <= CFG_BITS'(sy);
    @(posedge clk);
    cfg_we <= 1'b0;
    ew = (w == 0) ? 1 : (w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : w);
    eh = (h == 0) ? 1 : (h > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : h);
    cur_w  = ew;
    cur_h  = eh;
    cur_sx = sx;
    cur_sy = sy;
    // a full plane of loads covers every address whatever the load counter holds;
    // the store keeps earlier planes, so a plane inside one already loaded needs none
    if (ew * eh > covered) begin
      repeat (ew * eh) send_item(OP_LOAD, 16'($urandom()), 17'($urandom()), 17'($urandom()));
      covered = ew * eh;
    end
  endtask

  function automatic logic [16:0] pick_flow(int size, int sh);
    int r, span;
    r    = $urandom_range(0, 99);
    span = ((size + 1) * 32) << sh;
    if (span > 65535) span = 65535;
    if (r < 20) return 17'($urandom());
    if (r < 30) return 17'(($urandom_range(0, 2 * size + 2) - size - 1) * (32 << sh));
    return 17'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic warp_burst(int count);
    repeat (count) begin
      if ($urandom_range(0, 19) == 0)
        send_item(OP_LOAD, 16'($urandom()), 17'($urandom()), 17'($urandom()));
      else
        send_item(OP_COMPENSATE, 16'($urandom()),
                  pick_flow(cur_w, cur_sx), pick_flow(cur_h, cur_sy));
    end
  endtask

  initial begin
    loads_sent  = 0;
    warps_sent  = 0;
    send_gaps   = 1'b0;
    sink_stalls = 1'b0;
    stall_left  = 0;
    covered     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 4x3 luma plane, edges, fractions and extreme flows
    configure(4, 3, 0, 0);
    send_item(OP_COMPENSATE, 16'h0000, 17'd0, 17'd0);
    send_item(OP_COMPENSATE, 16'hFFFF, 17'h0FFFF, 17'd0);
    send_item(OP_COMPENSATE, 16'hFFFF, 17'h10000, 17'h10000);
    send_item(OP_COMPENSATE, 16'h1234, 17'd16, 17'd0);
    send_item(OP_COMPENSATE, 16'h1234, 17'd0, 17'd7);
    send_item(OP_COMPENSATE, 16'h5A5A, 17'(-65), 17'd64);
    send_item(OP_COMPENSATE, 16'hA5A5, 17'd32, 17'd33);
    send_item(OP_COMPENSATE, 16'h0001, 17'd0, 17'(-1));
    send_item(OP_COMPENSATE, 16'h8000, 17'(-96), 17'd0);
    send_item(OP_COMPENSATE, 16'h7FFF, 17'd31, 17'd31);
    send_item(OP_COMPENSATE, 16'hFFFF, 17'(-1), 17'd0);
    send_item(OP_COMPENSATE, 16'h0F0F, 17'(-1), 17'(-1));
    settle();
    // shift by three with odd negative flows, then zero and oversized sizes
    configure(3, 2, 3, 3);
    send_item(OP_COMPENSATE, 16'h00FF, 17'(-1), 17'(-9));
    send_item(OP_COMPENSATE, 16'hFF00, 17'd257, 17'd255);
    send_item(OP_COMPENSATE, 16'h3333, 17'h10000, 17'h0FFFF);
    settle();

    send_gaps   = 1'b1;
    sink_stalls = 1'b1;
    configure(0, 0, 0, 0);
    warp_burst(8);
    settle();
    configure(1023, 1, 1, 2);
    warp_burst(40);
    settle();
    configure(1, 1023, 2, 1);
    warp_burst(40);
    settle();

    repeat (8) begin
      send_gaps   = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      configure($urandom_range(1, 16), $urandom_range(1, 10),
                $urandom_range(0, 3), $urandom_range(0, 3));
      warp_burst($urandom_range(10, 20));
      settle();
    end

    $display("covered %0d loads and %0d compensates; %0d results, %0d passed through",
             loads_sent, warps_sent, pixels_seen, passes_seen);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
